// ----- hw/rtl/uart_line_command_matcher_unit_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef UART_LINE_COMMAND_MATCHER_UNIT_MACROS_SVH
`define UART_LINE_COMMAND_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ULCM_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ULCM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/ulcm_pkg.sv -----
package ulcm_pkg;

    localparam int WORD_COUNT = 8;
    localparam int WORD_MAX   = 17;
    localparam int POS_W      = 6;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [3:0] ACTION_NONE  = 4'd8;

    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [WORD_COUNT-1:0] t_word_mask;
    typedef logic [3:0]            t_action;

    // Strings are right-justified: the last character sits in bits [7:0].
    localparam logic [WORD_MAX*8-1:0] WORD_TEXT [WORD_COUNT] = '{
        "on_led",
        "off_led",
        {"led_left", "_on"},
        {"led_right", "_on"},
        {"led_left", "_keep_on"},
        {"led_right", "_keep_on"},
        {"led_flower", "_on"},
        {"led_flower", "_off"}
    };

    localparam t_pos WORD_LEN [WORD_COUNT] = '{
        6'd6, 6'd7, 6'd11, 6'd12, 6'd16, 6'd17, 6'd13, 6'd14
    };

    // Character of word k at line position pos; only meaningful for pos < WORD_LEN[k].
    function automatic logic [7:0] word_char(input int k, input t_pos pos);
        logic [4:0] off;
        off = 5'(WORD_LEN[k] - pos - 6'd1);
        return WORD_TEXT[k][off*8 +: 8];
    endfunction

endpackage

// ----- hw/rtl/uart_line_command_matcher_unit.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_rx_byte[7:0]
// result    out        o_out_valid / i_out_ready o_action[3:0], o_line_matched
//
// One byte per cycle: each byte below the line limit is compared against all eight
// words in the cycle it is taken, and a newline loads the result register in that same cycle.
// Only newline bytes produce a result; other bytes update the match state below the limit.
// Input is stalled only while a result is held and the sink is not ready.
// Synchronous active-low reset clears the line state and sets the action to none.
module uart_line_command_matcher_unit
    import ulcm_pkg::*;
#(
    parameter int LINE_LIMIT = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_action,
    output logic       o_line_matched
);

    localparam t_pos LIMIT = t_pos'(LINE_LIMIT);

    t_pos       r_pos,       n_pos;
    t_word_mask r_match,     n_match;
    t_action    r_action,    n_action;
    logic       r_out_valid, n_out_valid;
    logic       r_matched,   n_matched;

    logic       in_xfer;
    logic       is_newline;
    logic       hit;
    t_action    hit_idx;

    assign o_in_ready     = !r_out_valid || i_out_ready;
    assign in_xfer        = i_in_valid && o_in_ready;
    assign is_newline     = (i_rx_byte == NEWLINE_BYTE);
    assign o_out_valid    = r_out_valid;
    assign o_action       = r_action;
    assign o_line_matched = r_matched;

    // First word in priority order that still matches and was fully seen.
    always_comb begin
        hit     = 1'b0;
        hit_idx = ACTION_NONE;
        for (int k = WORD_COUNT - 1; k >= 0; k--) begin
            if (r_match[k] && (r_pos >= WORD_LEN[k])) begin
                hit     = 1'b1;
                hit_idx = t_action'(k);
            end
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_match     = r_match;
        n_action    = r_action;
        n_matched   = r_matched;
        n_out_valid = r_out_valid && !i_out_ready;
        if (in_xfer) begin
            if (is_newline) begin
                n_pos       = '0;
                n_match     = '1;
                n_out_valid = 1'b1;
                n_matched   = hit;
                if (hit) begin
                    n_action = hit_idx;
                end
            end else if (r_pos < LIMIT) begin
                // drop words that disagree at this position
                for (int k = 0; k < WORD_COUNT; k++) begin
                    if ((r_pos < WORD_LEN[k]) && (word_char(k, r_pos) != i_rx_byte)) begin
                        n_match[k] = 1'b0;
                    end
                end
                n_pos = r_pos + t_pos'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_match     <= '1;
            r_action    <= ACTION_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_match     <= n_match;
            r_action    <= n_action;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
    end

endmodule

// ----- hw/rtl/ulcm_checker.sv -----
`include "uart_line_command_matcher_unit_macros.svh"

module ulcm_checker
    import ulcm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_action,
    input logic       o_line_matched
);

    logic nl_xfer;
    assign nl_xfer = i_in_valid && o_in_ready && (i_rx_byte == NEWLINE_BYTE);

    `ULCM_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_action) && $stable(o_line_matched), "result changed while stalled")
    `ULCM_ASSERT_NEXT(a_newline_gives_result, i_clk, i_rst_n, nl_xfer, o_out_valid, "newline transfer gave no result")
    `ULCM_ASSERT_NEXT(a_no_invented_result, i_clk, i_rst_n, (!o_out_valid || i_out_ready) && !nl_xfer, !o_out_valid, "result without a newline transfer")
    `ULCM_ASSERT_NOW(a_matched_has_action, i_clk, i_rst_n, o_out_valid && o_line_matched, o_action != ACTION_NONE, "matched line reports no action")

endmodule

bind uart_line_command_matcher_unit ulcm_checker u_ulcm_checker (.*);

// ----- tb/uart_line_command_matcher_unit_test.sv -----
module uart_line_command_matcher_unit_test;
    import ulcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LIMIT   = 40;
    localparam int RANDOM_BYTES = 110;

    typedef struct packed {
        t_action action;
        logic    matched;
    } t_verdict;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_rx_byte      = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready    = 1'b0;
    logic [3:0] o_action;
    logic       o_line_matched;

    uart_line_command_matcher_unit #(
        .LINE_LIMIT(LINE_LIMIT)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action       (o_action),
        .o_line_matched (o_line_matched)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Command words in priority order.
    string cmd_words [8] = '{
        "on_led", "off_led", {"led_left", "_on"}, {"led_right", "_on"},
        {"led_left", "_keep_on"}, {"led_right", "_keep_on"},
        {"led_flower", "_on"}, {"led_flower", "_off"}
    };

    logic [7:0] rx_stream [$];
    t_verdict   verdict_q [$];
    t_verdict   head_verdict;

    // Predicted matcher state
    int         line_pos    = 0;
    logic [7:0] live_words  = 8'hFF;
    t_action    cur_action  = ACTION_NONE;

    int total_bytes    = 0;
    int bytes_sent     = 0;
    int bytes_accepted = 0;
    int lines_checked  = 0;
    int lines_matched  = 0;
    int fail_count     = 0;

    function automatic void match_command_byte(input logic [7:0] b);
        t_verdict v;
        bit       hit;
        if (b != NEWLINE_BYTE) begin
            if (line_pos < LINE_LIMIT) begin
                for (int k = 0; k < 8; k++) begin
                    if (line_pos < cmd_words[k].len() && cmd_words[k][line_pos] != b)
                        live_words[k] = 1'b0;
                end
                line_pos++;
            end
        end else begin
            hit = 1'b0;
            for (int k = 0; k < 8; k++) begin
                if (!hit && live_words[k] && line_pos >= cmd_words[k].len()) begin
                    cur_action = t_action'(k);
                    hit = 1'b1;
                end
            end
            v.action  = cur_action;
            v.matched = hit;
            verdict_q.push_back(v);
            line_pos   = 0;
            live_words = 8'hFF;
        end
    endfunction

    // Sender idles first lightly, then heavily, then not at all; receiver first heavily, then lightly, then not at all.
    function automatic int idle_pct(input bit sender);
        int phase;
        phase = (total_bytes == 0) ? 0 : (bytes_sent * 3) / total_bytes;
        case (phase)
            0:       return sender ? 6 : 57;
            1:       return sender ? 57 : 6;
            default: return 0;
        endcase
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rx_stream.push_back(s[i]);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            rx_stream.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic push_repeat(input logic [7:0] b, input int count);
        for (int i = 0; i < count; i++)
            rx_stream.push_back(b);
    endtask

    task automatic build_stream;
        int         k;
        int         cut;
        int         target;
        logic [7:0] b;
        // empty line and garbage before any command: action stays none
        rx_stream.push_back(NEWLINE_BYTE);
        push_text("xyz");
        rx_stream.push_back(NEWLINE_BYTE);
        for (k = 0; k < 8; k++) begin
            push_text(cmd_words[k]);
            rx_stream.push_back(NEWLINE_BYTE);
        end
        // short of a word, common prefix of two words
        push_text("on_le");
        rx_stream.push_back(NEWLINE_BYTE);
        push_text("led_flower_o");
        rx_stream.push_back(NEWLINE_BYTE);
        // trailing text after a word
        push_text("on_led and more");
        rx_stream.push_back(NEWLINE_BYTE);
        // zero bytes in front of, inside and after a word
        rx_stream.push_back(8'h00);
        push_text("on_led");
        rx_stream.push_back(NEWLINE_BYTE);
        push_text("on");
        rx_stream.push_back(8'h00);
        push_text("led");
        rx_stream.push_back(NEWLINE_BYTE);
        push_text("off_led");
        rx_stream.push_back(8'h00);
        rx_stream.push_back(NEWLINE_BYTE);
        // lines past the limit
        push_text(cmd_words[5]);
        push_repeat("x", 30);
        rx_stream.push_back(NEWLINE_BYTE);
        push_repeat(8'hFF, 63);
        rx_stream.push_back(NEWLINE_BYTE);
        push_repeat(8'h00, 45);
        rx_stream.push_back(NEWLINE_BYTE);
        push_repeat("a", LINE_LIMIT);
        push_text("on_led");
        rx_stream.push_back(NEWLINE_BYTE);
        push_text(cmd_words[4]);
        rx_stream.push_back(NEWLINE_BYTE);

        target = rx_stream.size() + RANDOM_BYTES;
        while (rx_stream.size() < target) begin
            case ($urandom_range(0, 9))
                0, 1: push_random($urandom_range(0, 60));
                2:    ;
                default: begin
                    k   = $urandom_range(0, 7);
                    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cmd_words[k].len() - 1)
                                                      : cmd_words[k].len();
                    for (int p = 0; p < cut; p++) begin
                        b = cmd_words[k][p];
                        if ($urandom_range(0, 24) == 0)
                            b = 8'($urandom_range(0, 255));
                        rx_stream.push_back(b);
                    end
                    push_random(($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                            : $urandom_range(0, 4));
                end
            endcase
            rx_stream.push_back(NEWLINE_BYTE);
        end
        total_bytes = rx_stream.size();
    endtask

    // Input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_rx_byte   <= 8'd0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || o_in_ready) begin
                if (rx_stream.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= rx_stream.pop_front();
                    bytes_sent++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
        end
    end

    // Monitor: check result transfers, then predict from the byte transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result: action=%0d matched=%0d",
                             $time, o_action, o_line_matched);
                    fail_count++;
                end else begin
                    head_verdict = verdict_q.pop_front();
                    lines_checked++;
                    if (head_verdict.matched)
                        lines_matched++;
                    if (o_action !== head_verdict.action) begin
                        $display("%0t: action mismatch: expected %0d, actual %0d",
                                 $time, head_verdict.action, o_action);
                        fail_count++;
                    end
                    if (o_line_matched !== head_verdict.matched) begin
                        $display("%0t: line_matched mismatch: expected %0d, actual %0d",
                                 $time, head_verdict.matched, o_line_matched);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                match_command_byte(i_rx_byte);
                bytes_accepted++;
            end
        end
    end

    initial begin
        build_stream();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (bytes_accepted < total_bytes)
            @(posedge i_clk);
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes; checked %0d line results, %0d of them command matches.",
                 bytes_accepted, lines_checked, lines_matched);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", verdict_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- uart_line_command_matcher_unit.f -----
+incdir+hw/rtl
hw/rtl/ulcm_pkg.sv
hw/rtl/uart_line_command_matcher_unit.sv
hw/rtl/ulcm_checker.sv
tb/uart_line_command_matcher_unit_test.sv
